/* design/kda_pkg.sv */
// Shared types and constants for the key debouncer with autorepeat.
// No dependencies; imported by kda_lane and key_debounce_autorepeat.
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

    // Per-key status kept by each lane
    typedef enum logic [1:0] {
        KS_IDLE    = 2'd0,
        KS_PRESS   = 2'd1,
        KS_AUTOREP = 2'd2,
        KS_LONG    = 2'd3
    } key_state_t;

    // Event codes carried on the output channel
    typedef enum logic [2:0] {
        EV_DOWN   = 3'd0,
        EV_UP     = 3'd1,
        EV_REPEAT = 3'd2,
        EV_LONG   = 3'd3,
        EV_RIGHT  = 3'd4,
        EV_LEFT   = 3'd5
    } ev_kind_t;

    // Key type codes, three bits per key in the type register
    localparam logic [2:0] TY_SIMPLE  = 3'd0;
    localparam logic [2:0] TY_AUTOREP = 3'd1;
    localparam logic [2:0] TY_LONG    = 3'd2;
    localparam logic [2:0] TY_ROTCLK  = 3'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_UPPER  = 3'd0;
    localparam logic [2:0] REG_LOWER  = 3'd1;
    localparam logic [2:0] REG_AR_DLY = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;
    localparam logic [2:0] REG_LP_DLY = 3'd4;
    localparam logic [2:0] REG_TYPES  = 3'd5;

    // Field widths fixed by the interface
    localparam int RAW_W      = 4;
    localparam int TYPES_W    = 12;
    localparam int TYPE_W     = 3;
    localparam int MAX_EVENTS = 4;
    localparam int CNT_W      = $clog2(MAX_EVENTS);

    // Timing and threshold settings shared by all lanes
    typedef struct packed {
        logic [7:0]  upper;
        logic [7:0]  lower;
        logic [15:0] ar_delay;
        logic [15:0] rep_period;
        logic [15:0] lp_delay;
    } kda_cfg_t;

    // Event found by one lane for the current word
    typedef struct packed {
        logic     valid;
        ev_kind_t kind;
    } lane_ev_t;

endpackage

`default_nettype wire

/* design/kda_lane.sv */
// One key lane: integrator, hysteresis, hold timer and per-type event logic.
// Depends on kda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kda_lane
    import kda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              acc,
    input  wire logic              raw,
    input  wire logic [TYPE_W-1:0] key_type,
    input  wire kda_cfg_t          cfg,
    input  wire logic              data_idle,
    output lane_ev_t               ev,
    output logic                   next_idle
);

    key_state_t  status_reg, status_next, st_upd;
    logic [7:0]  level_reg, level_next, lvl_new;
    logic [15:0] timer_reg, timer_next, timer_upd, t_inc;
    logic        rise, fall, held;

    // Move integrator a quarter of the way toward the sensed level
    always_comb
    begin
        if (raw)
            lvl_new = level_reg + ((8'hFF - level_reg) >> 2);
        else
            lvl_new = level_reg - (level_reg >> 2);
    end

    // Hysteresis and per-type event decision
    always_comb
    begin
        rise      = (status_reg == KS_IDLE) && (lvl_new > cfg.upper);
        fall      = (status_reg != KS_IDLE) && (lvl_new < cfg.lower);
        held      = (status_reg != KS_IDLE) && !fall;
        t_inc     = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
        st_upd    = status_reg;
        timer_upd = timer_reg;
        ev.valid  = 1'b0;
        ev.kind   = EV_DOWN;
        if (key_type <= TY_LONG)
        begin
            if (rise)
            begin
                ev.valid  = 1'b1;
                ev.kind   = EV_DOWN;
                timer_upd = '0;
                st_upd    = KS_PRESS;
            end
            else if (fall)
            begin
                if (status_reg == KS_PRESS)
                begin
                    ev.valid = 1'b1;
                    ev.kind  = EV_UP;
                end
                st_upd = KS_IDLE;
            end
            else if (held)
            begin
                timer_upd = t_inc;
                if (key_type == TY_AUTOREP)
                begin
                    if (status_reg == KS_PRESS && t_inc >= cfg.ar_delay)
                    begin
                        ev.valid  = 1'b1;
                        ev.kind   = EV_REPEAT;
                        timer_upd = '0;
                        st_upd    = KS_AUTOREP;
                    end
                    else if (status_reg == KS_AUTOREP && t_inc >= cfg.rep_period)
                    begin
                        ev.valid  = 1'b1;
                        ev.kind   = EV_REPEAT;
                        timer_upd = '0;
                    end
                end
                else if (key_type == TY_LONG)
                begin
                    if (status_reg == KS_PRESS && t_inc >= cfg.lp_delay)
                    begin
                        ev.valid = 1'b1;
                        ev.kind  = EV_LONG;
                        st_upd   = KS_LONG;
                    end
                end
            end
        end
        else
        begin
            // Unknown types track press and release only; a rotary clock pin also reports a turn on press
            if (rise)
            begin
                if (key_type == TY_ROTCLK)
                begin
                    ev.valid = 1'b1;
                    ev.kind  = data_idle ? EV_RIGHT : EV_LEFT;
                end
                st_upd = KS_PRESS;
            end
            else if (fall)
            begin
                st_upd = KS_IDLE;
            end
        end
        next_idle   = (st_upd == KS_IDLE);
        status_next = acc ? st_upd : status_reg;
        timer_next  = acc ? timer_upd : timer_reg;
        level_next  = acc ? lvl_new : level_reg;
    end

    // Hold lane state between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= KS_IDLE;
            level_reg  <= '0;
            timer_reg  <= '0;
        end
        else
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
            timer_reg  <= timer_next;
        end
    end

`ifndef SYNTHESIS
    // An idle key can only announce a press or a rotation
    a_idle_ev_kind: assert property (@(posedge clk) disable iff (!rst_n)
        acc && ev.valid && status_reg == KS_IDLE |->
        ev.kind == EV_DOWN || ev.kind == EV_RIGHT || ev.kind == EV_LEFT)
        else $error("idle key produced a hold event");

    // Lane state moves only on an accepted word
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(timer_reg) && $stable(level_reg) && $stable(status_reg))
        else $error("lane state changed without a word");

    // An up event always leaves the key idle
    a_up_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc && ev.valid && ev.kind == EV_UP |=> status_reg == KS_IDLE)
        else $error("up event did not return key to idle");
`endif

endmodule

`default_nettype wire

/* design/key_debounce_autorepeat.sv */
// Top level: configuration registers, key lanes and the event merge stage.
// Depends on kda_pkg and kda_lane.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_stall  | raw_levels
//   out     | output    | out_valid / out_stall| event_kind, key_index, last
//   wr      | input     | wr_en                | wr_index, wr_data
//
// All lanes update in the cycle a word is accepted; their events enter a
// batch register that the merge stage drains one word per cycle while the
// output is not stalled, highest key first, into the output register. A
// tick yields at most four events; the next word is taken in the cycle that
// drains the last event of the batch. Output stall holds the output register
// and the batch. Reset clears all key state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_autorepeat
    import kda_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [RAW_W-1:0]   raw_levels,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_kind,
    output logic [1:0]              key_index,
    output logic                    last,
    input  wire logic               wr_en,
    input  wire logic [2:0]         wr_index,
    input  wire logic [15:0]        wr_data
);

    kda_cfg_t             cfg_reg;
    logic [TYPES_W-1:0]   key_types_reg;

    lane_ev_t             lane_ev   [NUM_KEYS];
    logic [NUM_KEYS-1:0]  lane_idle;

    logic [NUM_KEYS-1:0]  pend_reg, pend_next;
    ev_kind_t             kind_reg  [NUM_KEYS];
    logic [CNT_W-1:0]     sent_reg, sent_next;

    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           event_kind_reg, event_kind_next;
    logic [1:0]           key_index_reg, key_index_next;
    logic                 last_reg, last_next;

    logic                 busy, out_free, out_load, pick_last, batch_done, in_acc;
    logic [NUM_KEYS-1:0]  pick_mask, remaining;
    logic [2:0]           sel;
    logic [2:0]           kind_sel;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper      <= 8'd192;
            cfg_reg.lower      <= 8'd64;
            cfg_reg.ar_delay   <= 16'd500;
            cfg_reg.rep_period <= 16'd100;
            cfg_reg.lp_delay   <= 16'd1000;
            key_types_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_UPPER:  cfg_reg.upper      <= wr_data[7:0];
                REG_LOWER:  cfg_reg.lower      <= wr_data[7:0];
                REG_AR_DLY: cfg_reg.ar_delay   <= wr_data;
                REG_PERIOD: cfg_reg.rep_period <= wr_data;
                REG_LP_DLY: cfg_reg.lp_delay   <= wr_data;
                REG_TYPES:  key_types_reg      <= wr_data[TYPES_W-1:0];
                default:    ;
            endcase
        end
    end

    // One lane per key; keys past the input width see no contact and type 0
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic              raw_k;
        logic [TYPE_W-1:0] type_k;
        logic              data_idle_k;

        if (k < RAW_W)
        begin : g_raw
            assign raw_k = raw_levels[k];
        end
        else
        begin : g_noraw
            assign raw_k = 1'b0;
        end

        if (TYPE_W * k + TYPE_W <= TYPES_W)
        begin : g_type
            assign type_k = key_types_reg[TYPE_W*k +: TYPE_W];
        end
        else
        begin : g_notype
            assign type_k = TY_SIMPLE;
        end

        // Rotary data pin is the next key up; missing one reads idle
        if (k == NUM_KEYS - 1)
        begin : g_top
            assign data_idle_k = 1'b1;
        end
        else
        begin : g_next
            assign data_idle_k = lane_idle[k+1];
        end

        kda_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .acc       (in_acc),
            .raw       (raw_k),
            .key_type  (type_k),
            .cfg       (cfg_reg),
            .data_idle (data_idle_k),
            .ev        (lane_ev[k]),
            .next_idle (lane_idle[k])
        );
    end

    // Pick the highest pending lane of the batch
    always_comb
    begin
        sel       = '0;
        kind_sel  = EV_DOWN;
        pick_mask = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (pend_reg[k])
            begin
                sel       = 3'(k);
                kind_sel  = kind_reg[k];
                pick_mask = NUM_KEYS'(1) << k;
            end
        end
        remaining = pend_reg & ~pick_mask;
    end

    // Handshake and batch control
    always_comb
    begin
        busy       = |pend_reg;
        out_free   = !out_valid_reg || !out_stall;
        out_load   = busy && out_free;
        pick_last  = (remaining == '0) || (sent_reg == CNT_W'(MAX_EVENTS - 1));
        batch_done = out_load && pick_last;
        in_stall   = busy && !batch_done;
        in_acc     = in_valid && !in_stall;

        if (in_acc)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                pend_next[k] = lane_ev[k].valid;
            end
        end
        else if (batch_done)
            pend_next = '0;
        else if (out_load)
            pend_next = remaining;
        else
            pend_next = pend_reg;

        if (in_acc || batch_done)
            sent_next = '0;
        else if (out_load)
            sent_next = sent_reg + CNT_W'(1);
        else
            sent_next = sent_reg;

        out_valid_next  = out_load ? 1'b1 : (out_valid_reg && out_stall);
        event_kind_next = out_load ? kind_sel : event_kind_reg;
        key_index_next  = out_load ? sel[1:0] : key_index_reg;
        last_next       = out_load ? pick_last : last_reg;
    end

    // Advance batch and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold event payloads
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                kind_reg[k] <= lane_ev[k].kind;
            end
        end
        event_kind_reg <= event_kind_next;
        key_index_reg  <= key_index_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign key_index  = key_index_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // Draining the last word empties the batch unless a new tick arrives
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        batch_done && !in_acc |=> !busy)
        else $error("batch not empty after last word");

    // Event counter rests at zero when nothing is pending
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> sent_reg == '0)
        else $error("event counter not cleared");

    // A word marked last is followed by no more words of the same batch
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && pick_last |=> pend_reg == '0 || $past(in_acc))
        else $error("words remain after last");
`endif

endmodule

`default_nettype wire
